[design/ttps_pkg.sv]
`timescale 1ns / 1ps

package ttps_pkg;

  // Number of table entries; must be a power of two so the index is the low key bits.
  localparam int unsigned TableEntries = 65536;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TableEntries - 1);

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned DepthW = 6;
  localparam int unsigned KindW  = 2;
  localparam int unsigned MoveW  = 7;

  localparam logic FuncProbe = 1'b0;
  localparam logic FuncStore = 1'b1;

  localparam logic [KindW-1:0] KindExact = 2'd0;
  localparam logic [KindW-1:0] KindLower = 2'd1;
  localparam logic [KindW-1:0] KindUpper = 2'd2;

  localparam logic [MoveW-1:0] NoMove = 7'd64;

  typedef struct packed {
    logic [KeyW-1:0]   tag;
    logic [ScoreW-1:0] score;
    logic [MoveW-1:0]  move;
    logic [KindW-1:0]  kind;
    logic [DepthW-1:0] depth;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

endpackage

[design/ttps_ram.sv]
`timescale 1ns / 1ps

module ttps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/transposition_table_probe_store_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake              Ports
// --------  ---------------------  -----------------------------------------------
// item in   start && !busy         func_i key_i search_depth_i alpha_i beta_i
//                                  score_in_i bound_kind_i move_in_i
// result    done_o (one cycle)     cutoff_o score_out_o move_found_o move_out_o
//                                  written_o
//
// For each item the entry is read from the table RAM in the idle state, and the
// hit and replacement decision and any write-back happen in the lookup state. The
// result is registered and shows on the cycle after, while the next item may
// already be accepted. After reset a clearing pass writes every entry to zero,
// one per cycle with busy high.
// Results cannot be stalled; done_o marks each one for a single cycle.

module transposition_table_probe_store_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func_i,
  input  logic [ttps_pkg::KeyW-1:0]       key_i,
  input  logic [ttps_pkg::DepthW-1:0]     search_depth_i,
  input  logic signed [ttps_pkg::ScoreW-1:0] alpha_i,
  input  logic signed [ttps_pkg::ScoreW-1:0] beta_i,
  input  logic signed [ttps_pkg::ScoreW-1:0] score_in_i,
  input  logic [ttps_pkg::KindW-1:0]      bound_kind_i,
  input  logic [ttps_pkg::MoveW-1:0]      move_in_i,
  output logic                            done_o,
  output logic                            cutoff_o,
  output logic signed [ttps_pkg::ScoreW-1:0] score_out_o,
  output logic                            move_found_o,
  output logic [ttps_pkg::MoveW-1:0]      move_out_o,
  output logic                            written_o
);

  import ttps_pkg::*;

  state_e state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;

  // Latched item.
  logic                     func_q;
  logic [KeyW-1:0]          key_q;
  logic [DepthW-1:0]        depth_q;
  logic signed [ScoreW-1:0] alpha_q;
  logic signed [ScoreW-1:0] beta_q;
  logic [ScoreW-1:0]        score_in_q;
  logic [KindW-1:0]         kind_q;
  logic [MoveW-1:0]         move_in_q;

  // Result registers.
  logic                     done_q;
  logic                     cutoff_q;
  logic [ScoreW-1:0]        score_out_q;
  logic                     found_q;
  logic [MoveW-1:0]         move_out_q;
  logic                     written_q;

  // RAM port signals.
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;
  logic [EntryW-1:0] ram_rdata;

  entry_t old_e;
  entry_t new_e;
  logic   tag_match;
  logic   hit;
  logic   use_score;
  logic   replace;

  ttps_ram #(
    .WIDTH(EntryW),
    .DEPTH(TableEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Decision logic on the entry read in the previous cycle.
  always_comb begin
    old_e     = entry_t'(ram_rdata);
    tag_match = (old_e.tag == key_q);
    hit       = tag_match && (old_e.depth >= depth_q);
    unique case (old_e.kind)
      KindExact: use_score = 1'b1;
      KindLower: use_score = $signed(old_e.score) >= beta_q;
      KindUpper: use_score = $signed(old_e.score) <= alpha_q;
      default:   use_score = 1'b0;
    endcase
    priority if (old_e.tag == '0) begin
      replace = 1'b1;
    end else if (tag_match) begin
      replace = (depth_q >= old_e.depth) || (kind_q == KindExact) ||
                (old_e.kind != KindExact);
    end else begin
      replace = depth_q > old_e.depth;
    end
    new_e.tag   = key_q;
    new_e.score = score_in_q;
    new_e.move  = move_in_q;
    new_e.kind  = kind_q;
    new_e.depth = depth_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = key_q[IdxW-1:0];
    ram_wdata = EntryW'(new_e);
    ram_re    = 1'b0;
    ram_raddr = key_i[IdxW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        ram_re = start;
      end
      ST_LOOKUP: begin
        ram_we = (func_q == FuncStore) && replace;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= (state_q == ST_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      func_q     <= func_i;
      key_q      <= key_i;
      depth_q    <= search_depth_i;
      alpha_q    <= alpha_i;
      beta_q     <= beta_i;
      score_in_q <= score_in_i;
      kind_q     <= bound_kind_i;
      move_in_q  <= move_in_i;
    end
    if (state_q == ST_LOOKUP) begin
      if (func_q == FuncStore) begin
        cutoff_q    <= 1'b0;
        score_out_q <= '0;
        found_q     <= 1'b0;
        move_out_q  <= NoMove;
        written_q   <= replace;
      end else begin
        cutoff_q    <= hit && use_score;
        score_out_q <= (hit && use_score) ? old_e.score : '0;
        found_q     <= hit;
        move_out_q  <= hit ? old_e.move : NoMove;
        written_q   <= 1'b0;
      end
    end
  end

  assign done_o       = done_q;
  assign cutoff_o     = cutoff_q;
  assign score_out_o  = $signed(score_out_q);
  assign move_found_o = found_q;
  assign move_out_o   = move_out_q;
  assign written_o    = written_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ttps_pkg::*;

  localparam logic signed [ScoreW-1:0] ScoreMin = 32'sh8000_0000;
  localparam logic signed [ScoreW-1:0] ScoreMax = 32'sh7FFF_FFFF;
  // The fourth kind code has no meaning of its own; it is stored but never gives a cutoff.
  localparam logic [KindW-1:0] KindSpare = 2'd3;
  localparam int RandomItems = 780;
  localparam int KeyPoolSize = 32;
  localparam int GapPct [4] = '{0, 48, 0, 10};

  typedef struct {
    logic                     func;
    logic [KeyW-1:0]          key;
    logic [DepthW-1:0]        depth;
    logic signed [ScoreW-1:0] alpha;
    logic signed [ScoreW-1:0] beta;
    logic signed [ScoreW-1:0] score;
    logic [KindW-1:0]         kind;
    logic [MoveW-1:0]         move;
    int unsigned              gap_pct;
    bit                       drain;
  } tt_req_t;

  typedef struct {
    logic                     cutoff;
    logic signed [ScoreW-1:0] score;
    logic                     found;
    logic [MoveW-1:0]         move;
    logic                     written;
  } tt_resp_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     func_i = FuncProbe;
  logic [KeyW-1:0]          key_i = '0;
  logic [DepthW-1:0]        search_depth_i = '0;
  logic signed [ScoreW-1:0] alpha_i = '0;
  logic signed [ScoreW-1:0] beta_i = '0;
  logic signed [ScoreW-1:0] score_in_i = '0;
  logic [KindW-1:0]         bound_kind_i = KindExact;
  logic [MoveW-1:0]         move_in_i = '0;
  logic                     done_o;
  logic                     cutoff_o;
  logic signed [ScoreW-1:0] score_out_o;
  logic                     move_found_o;
  logic [MoveW-1:0]         move_out_o;
  logic                     written_o;

  transposition_table_probe_store_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .key_i          (key_i),
    .search_depth_i (search_depth_i),
    .alpha_i        (alpha_i),
    .beta_i         (beta_i),
    .score_in_i     (score_in_i),
    .bound_kind_i   (bound_kind_i),
    .move_in_i      (move_in_i),
    .done_o         (done_o),
    .cutoff_o       (cutoff_o),
    .score_out_o    (score_out_o),
    .move_found_o   (move_found_o),
    .move_out_o     (move_out_o),
    .written_o      (written_o)
  );

  // Shadow copy of the table; 2-state arrays start out all zero like the cleared RAM.
  bit [KeyW-1:0]          shadow_tag   [TableEntries];
  bit signed [ScoreW-1:0] shadow_score [TableEntries];
  bit [DepthW-1:0]        shadow_depth [TableEntries];
  bit [KindW-1:0]         shadow_kind  [TableEntries];
  bit [MoveW-1:0]         shadow_move  [TableEntries];

  tt_req_t   pending_q [$];
  tt_resp_t  lookup_q [$];
  bit [KeyW-1:0] key_pool [KeyPoolSize];
  int err_cnt = 0;
  int probe_cnt = 0, hit_cnt = 0, cutoff_cnt = 0;
  int store_cnt = 0, write_cnt = 0, result_cnt = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void queue_item(tt_req_t r);
    pending_q = {pending_q, r};
  endfunction

  function automatic tt_resp_t access_table(tt_req_t r);
    logic [IdxW-1:0]          idx;
    logic [KeyW-1:0]          old_tag;
    logic signed [ScoreW-1:0] old_score;
    logic [DepthW-1:0]        old_depth;
    logic [KindW-1:0]         old_kind;
    bit                       usable;
    bit                       replace;
    tt_resp_t                 rs;
    idx = r.key[IdxW-1:0];
    old_tag = shadow_tag[idx];
    old_score = shadow_score[idx];
    old_depth = shadow_depth[idx];
    old_kind = shadow_kind[idx];
    rs = '{cutoff: 1'b0, score: '0, found: 1'b0, move: NoMove, written: 1'b0};
    if (r.func == FuncProbe) begin
      probe_cnt++;
      if (old_tag == r.key && old_depth >= r.depth) begin
        hit_cnt++;
        rs.found = 1'b1;
        rs.move = shadow_move[idx];
        case (old_kind)
          KindExact: usable = 1'b1;
          KindLower: usable = old_score >= r.beta;
          KindUpper: usable = old_score <= r.alpha;
          default:   usable = 1'b0;
        endcase
        if (usable) begin
          cutoff_cnt++;
          rs.cutoff = 1'b1;
          rs.score = old_score;
        end
      end
    end else begin
      store_cnt++;
      if (old_tag == '0) begin
        replace = 1'b1;
      end else if (old_tag == r.key) begin
        replace = r.depth >= old_depth || r.kind == KindExact || old_kind != KindExact;
      end else begin
        replace = r.depth > old_depth;
      end
      if (replace) begin
        write_cnt++;
        shadow_tag[idx] = r.key;
        shadow_score[idx] = r.score;
        shadow_depth[idx] = r.depth;
        shadow_kind[idx] = r.kind;
        shadow_move[idx] = r.move;
        rs.written = 1'b1;
      end
    end
    return rs;
  endfunction

  function automatic logic signed [ScoreW-1:0] pick_score();
    case ($urandom_range(5))
      0: return ScoreMin;
      1: return ScoreMax;
      2: return '0;
      3: return $signed(32'($urandom_range(512))) - 32'sd256;
      default: return $urandom;
    endcase
  endfunction

  function automatic tt_req_t dir_req(logic f, logic [KeyW-1:0] k, int d, logic [KindW-1:0] kd,
                                      logic signed [ScoreW-1:0] sc, int mv,
                                      logic signed [ScoreW-1:0] al,
                                      logic signed [ScoreW-1:0] be);
    tt_req_t r;
    r = '{func: f, key: k, depth: DepthW'(d), alpha: al, beta: be, score: sc, kind: kd,
          move: MoveW'(mv), gap_pct: 0, drain: 1'b0};
    return r;
  endfunction

  function automatic tt_req_t rand_req(int unsigned gap);
    tt_req_t r;
    r.func = ($urandom_range(99) < 55) ? FuncStore : FuncProbe;
    if ($urandom_range(99) < 85) begin
      r.key = key_pool[$urandom_range(KeyPoolSize - 1)];
    end else begin
      r.key = {$urandom, $urandom};
    end
    // Probes ask for shallow depth more often so that stored entries hit.
    if (r.func == FuncProbe && $urandom_range(1) == 0) begin
      r.depth = DepthW'($urandom_range(15));
    end else begin
      r.depth = DepthW'($urandom_range(63));
    end
    r.kind = ($urandom_range(9) == 0) ? KindSpare : KindW'($urandom_range(2));
    r.move = ($urandom_range(9) == 0) ? MoveW'($urandom_range(127)) :
                                        MoveW'($urandom_range(64));
    r.score = pick_score();
    r.alpha = pick_score();
    r.beta = pick_score();
    r.gap_pct = gap;
    r.drain = 1'b0;
    return r;
  endfunction

  // Item driver: presents the head of pending_q and holds it until the block takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        lookup_q = {lookup_q, access_table(pending_q.pop_front())};
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && !(pending_q[0].drain && lookup_q.size() != 0) &&
            $urandom_range(99) >= pending_q[0].gap_pct) begin
          start <= 1'b1;
          func_i <= pending_q[0].func;
          key_i <= pending_q[0].key;
          search_depth_i <= pending_q[0].depth;
          alpha_i <= pending_q[0].alpha;
          beta_i <= pending_q[0].beta;
          score_in_i <= pending_q[0].score;
          bound_kind_i <= pending_q[0].kind;
          move_in_i <= pending_q[0].move;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    tt_resp_t exp_rs;
    if (rst_ni && done_o) begin
      result_cnt++;
      if (lookup_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected (cutoff %0b score %0d move_found %0b",
                 $time, cutoff_o, score_out_o, move_found_o);
        $display("%0t:   move %0d written %0b)", $time, move_out_o, written_o);
      end else begin
        exp_rs = lookup_q.pop_front();
        if (cutoff_o !== exp_rs.cutoff) begin
          err_cnt++;
          $display("%0t: cutoff expected %0b actual %0b", $time, exp_rs.cutoff, cutoff_o);
        end
        if (score_out_o !== exp_rs.score) begin
          err_cnt++;
          $display("%0t: score_out expected %0d actual %0d", $time, exp_rs.score, score_out_o);
        end
        if (move_found_o !== exp_rs.found) begin
          err_cnt++;
          $display("%0t: move_found expected %0b actual %0b", $time, exp_rs.found,
                   move_found_o);
        end
        if (move_out_o !== exp_rs.move) begin
          err_cnt++;
          $display("%0t: move_out expected %0d actual %0d", $time, exp_rs.move, move_out_o);
        end
        if (written_o !== exp_rs.written) begin
          err_cnt++;
          $display("%0t: written expected %0b actual %0b", $time, exp_rs.written, written_o);
        end
      end
    end
  end

  initial begin
    logic [KeyW-1:0] k_ones, k_alias, k_zero_idx;
    logic [IdxW-1:0] idx_pick [8];
    tt_req_t r;
    k_ones = '1;
    k_alias = 64'h0123_4567_89AB_FFFF;
    k_zero_idx = 64'h0000_0000_0001_0000;

    // The reset entry at index zero reads as an exact depth-zero hit for key zero.
    queue_item(dir_req(FuncProbe, '0, 0, KindExact, '0, 0, '0, '0));
    queue_item(dir_req(FuncProbe, '0, 1, KindExact, '0, 0, '0, '0));
    queue_item(dir_req(FuncProbe, k_ones, 0, KindExact, '0, 0, ScoreMin, ScoreMax));
    queue_item(dir_req(FuncStore, k_ones, 10, KindExact, ScoreMax, NoMove, '0, '0));
    queue_item(dir_req(FuncProbe, k_ones, 10, KindExact, '0, 0, ScoreMax, ScoreMin));
    queue_item(dir_req(FuncProbe, k_ones, 11, KindExact, '0, 0, '0, '0));
    // Same tag, shallower, not exact over an exact entry: kept.
    queue_item(dir_req(FuncStore, k_ones, 5, KindLower, 32'sd5, 1, '0, '0));
    queue_item(dir_req(FuncStore, k_ones, 5, KindExact, ScoreMin, 0, '0, '0));
    // A different tag on the same index needs strictly greater depth.
    queue_item(dir_req(FuncStore, k_alias, 5, KindExact, '0, 2, '0, '0));
    queue_item(dir_req(FuncStore, k_alias, 6, KindLower, 32'sd256, 63, '0, '0));
    queue_item(dir_req(FuncProbe, k_alias, 6, KindExact, '0, 0, '0, 32'sd256));
    queue_item(dir_req(FuncProbe, k_alias, 0, KindExact, '0, 0, '0, 32'sd257));
    queue_item(dir_req(FuncStore, k_alias, 6, KindUpper, '0, 9, '0, '0));
    queue_item(dir_req(FuncProbe, k_alias, 6, KindExact, '0, 0, '0, ScoreMax));
    queue_item(dir_req(FuncProbe, k_alias, 6, KindExact, '0, 0, -32'sd1, ScoreMin));
    queue_item(dir_req(FuncStore, k_alias, 7, KindSpare, ScoreMax, 127, '0, '0));
    queue_item(dir_req(FuncProbe, k_alias, 7, KindExact, '0, 0, ScoreMax, ScoreMin));
    queue_item(dir_req(FuncStore, k_alias, 1, KindLower, ScoreMin, 100, '0, '0));
    queue_item(dir_req(FuncProbe, k_alias, 1, KindExact, '0, 0, '0, ScoreMin));
    // A store of key zero leaves the entry looking empty to the next store.
    queue_item(dir_req(FuncStore, '0, 63, KindExact, 32'sd77, 3, '0, '0));
    queue_item(dir_req(FuncProbe, '0, 63, KindExact, '0, 0, '0, '0));
    queue_item(dir_req(FuncStore, k_zero_idx, 0, KindUpper, ScoreMin, 64, '0, '0));
    queue_item(dir_req(FuncProbe, '0, 0, KindExact, '0, 0, '0, '0));
    queue_item(dir_req(FuncProbe, k_zero_idx, 0, KindExact, '0, 0, ScoreMin, '0));

    // Keys cluster on a few indexes so that tags collide and entries get replaced.
    idx_pick = '{16'h0000, 16'h0001, 16'hFFFF, 16'h1234, 16'h8000, 16'h00FF,
                 IdxW'($urandom), IdxW'($urandom)};
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][IdxW-1:0] = idx_pick[$urandom_range(7)];
    end
    key_pool[0] = '0;

    for (int i = 0; i < RandomItems; i++) begin
      r = rand_req(GapPct[(i * 4) / RandomItems]);
      if (i % 150 == 0) r.drain = 1'b1;
      queue_item(r);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || start) @(posedge clk_i);
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results: %0d probes (%0d hits, %0d cutoffs),",
             result_cnt, probe_cnt, hit_cnt, cutoff_cnt);
    $display("  %0d stores (%0d written); sender gaps of 0, 48 and 10 percent, with drains.",
             store_cnt, write_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // This timeout leaves ample room beyond the clearing pass.
  initial begin
    #3_000_000;
    $display("Timeout with %0d items unsent and %0d results outstanding.",
             pending_q.size(), lookup_q.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
